[rtl/core/tksd_pkg.sv]
// Shared types and constants for the terminal key sequence decoder.
`timescale 1ns / 1ps
package tksd_pkg;

  localparam logic [7:0] ByteEsc = 8'h1B;
  localparam logic [15:0] SatMax = 16'hFFFF;

  localparam logic [5:0] KcPlain    = 6'd0;
  localparam logic [5:0] KcEsc      = 6'd1;
  localparam logic [5:0] KcCtrl     = 6'd2;
  localparam logic [5:0] KcUp       = 6'd3;
  localparam logic [5:0] KcDown     = 6'd4;
  localparam logic [5:0] KcLeft     = 6'd5;
  localparam logic [5:0] KcRight    = 6'd6;
  localparam logic [5:0] KcSUp      = 6'd7;
  localparam logic [5:0] KcSDown    = 6'd8;
  localparam logic [5:0] KcSLeft    = 6'd9;
  localparam logic [5:0] KcSRight   = 6'd10;
  localparam logic [5:0] KcALeft    = 6'd11;
  localparam logic [5:0] KcARight   = 6'd12;
  localparam logic [5:0] KcHome     = 6'd13;
  localparam logic [5:0] KcEnd      = 6'd14;
  localparam logic [5:0] KcSHome    = 6'd15;
  localparam logic [5:0] KcSEnd     = 6'd16;
  localparam logic [5:0] KcDHome    = 6'd17;
  localparam logic [5:0] KcDEnd     = 6'd18;
  localparam logic [5:0] KcSdHome   = 6'd19;
  localparam logic [5:0] KcSdEnd    = 6'd20;
  localparam logic [5:0] KcPgUp     = 6'd21;
  localparam logic [5:0] KcPgDn     = 6'd22;
  localparam logic [5:0] KcSPgUp    = 6'd23;
  localparam logic [5:0] KcSPgDn    = 6'd24;
  localparam logic [5:0] KcDel      = 6'd25;
  localparam logic [5:0] KcF1       = 6'd26;
  localparam logic [5:0] KcF2       = 6'd27;
  localparam logic [5:0] KcF3       = 6'd28;
  localparam logic [5:0] KcF4       = 6'd29;
  localparam logic [5:0] KcBackTab  = 6'd30;
  localparam logic [5:0] KcPaste    = 6'd31;
  localparam logic [5:0] KcSaveAs   = 6'd32;
  localparam logic [5:0] KcMouse    = 6'd33;

  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
  } tksd_in_t;

  typedef struct packed {
    logic [5:0]  key_code;
    logic [7:0]  key_value;
    logic [15:0] mouse_button;
    logic [15:0] mouse_column;
    logic [15:0] mouse_row;
    logic        mouse_pressed;
  } tksd_out_t;

  // Saturating decimal accumulate: v * 10 + digit, clamped to 16 bits.
  function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [7:0] b);
    logic [19:0] s;
    s = {v, 3'b000} + {3'b000, v, 1'b0} + {12'd0, b - 8'h30};
    acc_digit = (s > 20'(SatMax)) ? SatMax : s[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_final(input logic [7:0] b);
    is_final = (b >= 8'h40) && (b <= 8'h7E);
  endfunction

endpackage

[rtl/core/tksd_if.sv]
// Valid/ready channel interface carrying one word of a given type.
`timescale 1ns / 1ps
interface tksd_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/terminal_key_sequence_decoder_core.sv]
// Top level of the terminal key sequence decoder: input stage, parser, result stage.
`timescale 1ns / 1ps
// An accepted word's key event (if any) is written into the result register that drives the output.
// Throughput: one word per cycle while results are taken; the parser state and result register are the only loop.
// The result register is a single output stage: input is ready while it is empty or being
// read this cycle, so a result that waits on the output side holds the input.
// Reset: asynchronous, active low; parser goes idle with all its fields zero, mapping bit off.
module terminal_key_sequence_decoder_core
  import tksd_pkg::*;
#(
  parameter int DRAIN_LIMIT = 16,
  parameter int MOUSE_GUARD = 32,
  parameter int KEY_GUARD   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  tksd_if.sink   in_i,
  tksd_if.source out_o
);

  logic      map_q;
  logic      step;
  logic      emit;
  tksd_out_t res;
  logic      ovalid_q;
  tksd_out_t odata_q;

  // A word is taken when the result slot is empty or being emptied this cycle.
  assign in_i.ready = !ovalid_q || out_o.ready;
  assign step = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) map_q <= 1'b0;
    else if (cfg_we_i) map_q <= cfg_wdata_i;
  end

  tksd_parser #(
    .DRAIN_LIMIT(DRAIN_LIMIT), .MOUSE_GUARD(MOUSE_GUARD), .KEY_GUARD(KEY_GUARD)
  ) u_parser (
    .clk_i, .rst_ni,
    .step_i(step), .word_i(in_i.data), .cmd_map_i(map_q),
    .emit_o(emit), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (in_i.ready) ovalid_q <= step && emit;
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) odata_q <= res;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = odata_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_o.ready |=> ovalid_q && $stable(odata_q))
    else $error("result lost under stall");
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> odata_q.key_code <= KcMouse)
    else $error("key code out of range");
  a_mouse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && odata_q.key_code != KcMouse |-> odata_q.mouse_pressed == 1'b0)
    else $error("mouse flag on non-mouse key");

endmodule

[rtl/core/tksd_parser.sv]
// Byte-level parser: state update and result decode for one input word.
`timescale 1ns / 1ps
module tksd_parser
  import tksd_pkg::*;
#(
  parameter int DRAIN_LIMIT = 16,
  parameter int MOUSE_GUARD = 32,
  parameter int KEY_GUARD   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  tksd_in_t  word_i,
  input  logic      cmd_map_i,
  output logic      emit_o,
  output tksd_out_t res_o
);

  typedef enum logic [3:0] {
    PhIdle, PhEsc, PhIntro, PhCsiDigit, PhPasteDigit, PhPasteTerm,
    PhF13Term, PhCsiu, PhNavMod, PhNavTerm, PhMouse, PhDrain
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  first_q, first_d, second_q, second_d, mod_q, mod_d;
  logic [15:0] num_q [3];
  logic [15:0] num_d [3];
  logic [1:0]  fidx_q, fidx_d;
  logic [5:0]  guard_q, guard_d;
  logic [4:0]  drain_q, drain_d;

  logic [7:0]  b;
  logic [5:0]  gnext;
  logic [4:0]  dnext;
  logic        alt, sh, ct, cs;

  assign b     = word_i.data_byte;
  assign gnext = guard_q + 6'd1;
  assign dnext = drain_q + 5'd1;
  assign alt   = mod_q == "3";
  assign sh    = mod_q == "2";
  assign ct    = mod_q == "5";
  assign cs    = mod_q == "6";

  always_comb begin
    phase_d = phase_q;
    first_d = first_q; second_d = second_q; mod_d = mod_q;
    num_d = num_q; fidx_d = fidx_q; guard_d = guard_q; drain_d = drain_q;
    emit_o = 1'b0;
    res_o = '0;

    if (word_i.command) begin
      if (phase_q != PhIdle) begin
        emit_o = 1'b1; res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
      end
      phase_d = PhIdle;
    end else begin
      unique case (phase_q)
        PhEsc: begin
          if (b == "b") begin
            emit_o = 1'b1; res_o.key_code = KcALeft; phase_d = PhIdle;
          end else if (b == "f") begin
            emit_o = 1'b1; res_o.key_code = KcARight; phase_d = PhIdle;
          end else begin
            first_d = b; phase_d = PhIntro;
          end
        end
        PhIntro: begin
          second_d = b;
          emit_o = 1'b1; phase_d = PhIdle; res_o.key_code = KcEsc;
          if (first_q == "[") begin
            case (b)
              "P": res_o.key_code = KcF1;
              "Q": res_o.key_code = KcF2;
              "R": res_o.key_code = KcF3;
              "S": res_o.key_code = KcF4;
              "A": res_o.key_code = KcUp;
              "B": res_o.key_code = KcDown;
              "C": res_o.key_code = KcRight;
              "D": res_o.key_code = KcLeft;
              "H": res_o.key_code = KcHome;
              "F": res_o.key_code = KcEnd;
              "Z": res_o.key_code = KcBackTab;
              "<": begin
                emit_o = 1'b0; phase_d = PhMouse;
                num_d[0] = '0; num_d[1] = '0; num_d[2] = '0;
                fidx_d = '0; guard_d = '0;
              end
              "?": begin
                emit_o = 1'b0; phase_d = PhDrain; drain_d = '0;
              end
              default: begin
                if (is_digit(b)) begin
                  emit_o = 1'b0; phase_d = PhCsiDigit;
                end
              end
            endcase
          end else if (first_q == "O") begin
            case (b)
              "H": res_o.key_code = KcHome;
              "F": res_o.key_code = KcEnd;
              "P": res_o.key_code = KcF1;
              "Q": res_o.key_code = KcF2;
              "R": res_o.key_code = KcF3;
              "S": res_o.key_code = KcF4;
              default: ;
            endcase
          end
          if (res_o.key_code == KcEsc) res_o.key_value = ByteEsc;
        end
        PhCsiDigit: begin
          if (b == "~") begin
            emit_o = 1'b1; phase_d = PhIdle;
            case (second_q)
              "1", "7": res_o.key_code = KcHome;
              "4", "8": res_o.key_code = KcEnd;
              "3":      res_o.key_code = KcDel;
              "5":      res_o.key_code = KcPgUp;
              "6":      res_o.key_code = KcPgDn;
              default: begin
                res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
              end
            endcase
          end else if (second_q == "2" && b == "0") begin
            phase_d = PhPasteDigit;
          end else if (second_q == "1" && b == "3") begin
            phase_d = PhF13Term;
          end else if (is_digit(b)) begin
            num_d[0] = 16'(acc_digit(16'(second_q - 8'h30), b));
            num_d[1] = '0; num_d[2] = '0;
            fidx_d = '0; guard_d = '0; phase_d = PhCsiu;
          end else if (b == ";") begin
            phase_d = PhNavMod;
          end else begin
            emit_o = 1'b1; phase_d = PhIdle;
            res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
          end
        end
        PhPasteDigit: begin
          mod_d = b; phase_d = PhPasteTerm;
        end
        PhPasteTerm: begin
          emit_o = 1'b1; phase_d = PhIdle;
          if (b == "~" && mod_q == "0") res_o.key_code = KcPaste;
          else begin
            res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
          end
        end
        PhF13Term: begin
          emit_o = 1'b1; phase_d = PhIdle;
          if (b == "~") res_o.key_code = KcF3;
          else begin
            res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
          end
        end
        PhCsiu, PhMouse: begin
          guard_d = gnext;
          if (is_digit(b)) begin
            if (fidx_q != 2'd3) num_d[fidx_q] = acc_digit(num_q[fidx_q], b);
            if (phase_q == PhCsiu && gnext >= 6'(KEY_GUARD)) begin
              emit_o = 1'b1; phase_d = PhIdle;
              res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
            end else if (phase_q == PhMouse && gnext >= 6'(MOUSE_GUARD)) begin
              phase_d = PhDrain; drain_d = '0;
            end
          end else if (b == ";") begin
            if ((phase_q == PhCsiu && fidx_q >= 2'd1) ||
                (phase_q == PhMouse && fidx_q >= 2'd2)) begin
              phase_d = PhDrain; drain_d = '0;
            end else begin
              fidx_d = fidx_q + 2'd1;
              if (phase_q == PhCsiu && gnext >= 6'(KEY_GUARD)) begin
                emit_o = 1'b1; phase_d = PhIdle;
                res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
              end else if (phase_q == PhMouse && gnext >= 6'(MOUSE_GUARD)) begin
                phase_d = PhDrain; drain_d = '0;
              end
            end
          end else if (phase_q == PhCsiu && b == "u") begin
            emit_o = 1'b1; phase_d = PhIdle;
            res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
            if (fidx_q == 2'd1) begin
              if (num_q[1] == 16'd9 && cmd_map_i) begin
                case (num_q[0])
                  "s", "f", "z", "o", "w", "c", "x", "a", "q", "g", "r", "t", "y", "d":
                  begin
                    res_o.key_code = KcCtrl; res_o.key_value = {3'b000, num_q[0][4:0]};
                  end
                  default: ;
                endcase
              end else if (num_q[0] == 16'd115 && num_q[1] == 16'd6) begin
                res_o.key_code = KcSaveAs; res_o.key_value = '0;
              end else if ((num_q[1] == 16'd5 || num_q[1] == 16'd6) &&
                           num_q[0] >= 16'h61 && num_q[0] <= 16'h7A) begin
                res_o.key_code = KcCtrl; res_o.key_value = {3'b000, num_q[0][4:0]};
              end
            end
          end else if (phase_q == PhMouse && (b == "M" || b == "m")) begin
            if (fidx_q != 2'd2) begin
              phase_d = PhDrain; drain_d = '0;
            end else begin
              emit_o = 1'b1; phase_d = PhIdle;
              res_o.key_code = KcMouse;
              res_o.mouse_button = num_q[0];
              res_o.mouse_column = num_q[1];
              res_o.mouse_row = num_q[2];
              res_o.mouse_pressed = b == "M";
            end
          end else begin
            phase_d = PhDrain; drain_d = '0;
          end
        end
        PhNavMod: begin
          mod_d = b; phase_d = PhNavTerm;
        end
        PhNavTerm: begin
          emit_o = 1'b1; phase_d = PhIdle;
          if (second_q == "5" && b == "~") begin
            res_o.key_code = cs ? KcSdHome : ct ? KcDHome : sh ? KcSPgUp : KcPgUp;
          end else if (second_q == "6" && b == "~") begin
            res_o.key_code = cs ? KcSdEnd : ct ? KcDEnd : sh ? KcSPgDn : KcPgDn;
          end else begin
            case (b)
              "P": res_o.key_code = KcF1;
              "Q": res_o.key_code = KcF2;
              "R": res_o.key_code = KcF3;
              "S": res_o.key_code = KcF4;
              "A": res_o.key_code = sh ? KcSUp : KcUp;
              "B": res_o.key_code = sh ? KcSDown : KcDown;
              "C": res_o.key_code = alt ? KcARight : sh ? KcSRight : KcRight;
              "D": res_o.key_code = alt ? KcALeft : sh ? KcSLeft : KcLeft;
              "H": res_o.key_code = cs ? KcSdHome : ct ? KcDHome : sh ? KcSHome : KcHome;
              "F": res_o.key_code = cs ? KcSdEnd : ct ? KcDEnd : sh ? KcSEnd : KcEnd;
              default: begin
                if (is_final(b)) begin
                  res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
                end else begin
                  emit_o = 1'b0; phase_d = PhDrain; drain_d = '0;
                end
              end
            endcase
          end
        end
        PhDrain: begin
          drain_d = dnext;
          if (is_final(b) || dnext >= 5'(DRAIN_LIMIT)) begin
            emit_o = 1'b1; phase_d = PhIdle;
            res_o.key_code = KcEsc; res_o.key_value = ByteEsc;
          end
        end
        default: begin
          if (b == ByteEsc) phase_d = PhEsc;
          else begin
            emit_o = 1'b1; phase_d = PhIdle;
            res_o.key_code = KcPlain; res_o.key_value = b;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      first_q <= '0; second_q <= '0; mod_q <= '0;
      num_q[0] <= '0; num_q[1] <= '0; num_q[2] <= '0;
      fidx_q <= '0; guard_q <= '0; drain_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      first_q <= first_d; second_q <= second_d; mod_q <= mod_d;
      num_q <= num_d;
      fidx_q <= fidx_d; guard_q <= guard_d; drain_q <= drain_d;
    end
  end

  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDrain |-> drain_q < 5'(DRAIN_LIMIT))
    else $error("drain count past limit");
  a_fidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fidx_q != 2'd3)
    else $error("field index out of range");
  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && word_i.command |=> phase_q == PhIdle)
    else $error("timeout did not return to idle");

endmodule

[verif/terminal_key_sequence_decoder_core_tb.sv]
// Self-checking testbench for the terminal key sequence decoder core.
`timescale 1ns / 1ps
module terminal_key_sequence_decoder_core_tb;
  import tksd_pkg::*;

  // Parser phases of the predictor; they mirror the decoder's documented behavior.
  typedef enum logic [4:0] {
    PhIdle, PhEsc, PhIntro, PhCsiDigit, PhPasteDigit, PhPasteTerm,
    PhF13Term, PhCsiu, PhNavMod, PhNavTerm, PhMouse, PhDrain
  } phase_e;

  localparam int DrainLimit = 16;
  localparam int MouseGuard = 32;
  localparam int KeyGuard   = 16;
  localparam int WatchLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  tksd_if #(.word_t(tksd_in_t))  in_ch ();
  tksd_if #(.word_t(tksd_out_t)) out_ch ();

  terminal_key_sequence_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state, kept in step with every accepted word.
  phase_e      phase;
  logic [7:0]  seq_first, seq_second, mod_byte;
  logic [15:0] num_field [3];
  int          fld_sel, guard_cnt, drain_cnt;
  logic        super_map;

  tksd_out_t key_events [$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        events_seen = 0;
  int        words_sent = 0;

  // Clear the predictor to its reset state.
  task automatic clear_predictor();
    phase = PhIdle;
    seq_first = '0; seq_second = '0; mod_byte = '0;
    for (int i = 0; i < 3; i++) num_field[i] = '0;
    fld_sel = 0; guard_cnt = 0; drain_cnt = 0;
    super_map = 1'b0;
  endtask

  // Queue one key event and return the parser to idle.
  task automatic emit_key(input logic [5:0] code, input logic [7:0] val);
    tksd_out_t ev;
    ev = '0;
    ev.key_code = code;
    ev.key_value = val;
    key_events.push_back(ev);
    phase = PhIdle;
  endtask

  task automatic begin_drain();
    phase = PhDrain;
    drain_cnt = 0;
  endtask

  function automatic logic digit_byte(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic final_byte(input logic [7:0] b);
    return b >= 8'h40 && b <= 8'h7E;
  endfunction

  // Saturating times-ten accumulate into the current decimal field.
  task automatic add_digit(input logic [7:0] b);
    int unsigned sum;
    if (fld_sel > 2) return;
    sum = num_field[fld_sel] * 10 + (b - 8'h30);
    num_field[fld_sel] = (sum > 65535) ? 16'hFFFF : sum[15:0];
  endtask

  // Finish a CSI-u key: Ctrl letters, Save-As and the optional Super mapping.
  task automatic finish_csiu();
    int unsigned key, modv;
    logic hit;
    string letters;
    letters = "sfzowcxaqgrtyd";
    key = num_field[0];
    modv = num_field[1];
    if (modv == 9 && super_map) begin
      hit = 1'b0;
      for (int i = 0; i < letters.len(); i++) begin
        if (key == letters[i]) hit = 1'b1;
      end
      if (hit) emit_key(KcCtrl, key[7:0] & 8'h1F);
      else emit_key(KcEsc, ByteEsc);
    end else if (key == 115 && modv == 6) begin
      emit_key(KcSaveAs, 8'h00);
    end else if ((modv == 5 || modv == 6) && key >= "a" && key <= "z") begin
      emit_key(KcCtrl, key[7:0] & 8'h1F);
    end else begin
      emit_key(KcEsc, ByteEsc);
    end
  endtask

  // Finish a modified navigation key ESC [ n ; m x.
  task automatic finish_nav(input logic [7:0] t);
    logic alt, sh, ct, cs;
    alt = mod_byte == "3"; sh = mod_byte == "2";
    ct = mod_byte == "5";  cs = mod_byte == "6";
    if (seq_second == "5" && t == "~")
      emit_key(cs ? KcSdHome : ct ? KcDHome : sh ? KcSPgUp : KcPgUp, 8'h00);
    else if (seq_second == "6" && t == "~")
      emit_key(cs ? KcSdEnd : ct ? KcDEnd : sh ? KcSPgDn : KcPgDn, 8'h00);
    else begin
      case (t)
        "P": emit_key(KcF1, 8'h00);
        "Q": emit_key(KcF2, 8'h00);
        "R": emit_key(KcF3, 8'h00);
        "S": emit_key(KcF4, 8'h00);
        "A": emit_key(sh ? KcSUp : KcUp, 8'h00);
        "B": emit_key(sh ? KcSDown : KcDown, 8'h00);
        "C": emit_key(alt ? KcARight : sh ? KcSRight : KcRight, 8'h00);
        "D": emit_key(alt ? KcALeft : sh ? KcSLeft : KcLeft, 8'h00);
        "H": emit_key(cs ? KcSdHome : ct ? KcDHome : sh ? KcSHome : KcHome, 8'h00);
        "F": emit_key(cs ? KcSdEnd : ct ? KcDEnd : sh ? KcSEnd : KcEnd, 8'h00);
        default: begin
          // An unknown final byte ends the sequence; anything else drains first.
          if (!final_byte(t)) begin_drain();
          else emit_key(KcEsc, ByteEsc);
        end
      endcase
    end
  endtask

  // Byte right after ESC [ or ESC O; after any other introducer it gives an ESC.
  task automatic finish_intro(input logic [7:0] b);
    if (seq_first == "[") begin
      case (b)
        "P": emit_key(KcF1, 8'h00);
        "Q": emit_key(KcF2, 8'h00);
        "R": emit_key(KcF3, 8'h00);
        "S": emit_key(KcF4, 8'h00);
        "A": emit_key(KcUp, 8'h00);
        "B": emit_key(KcDown, 8'h00);
        "C": emit_key(KcRight, 8'h00);
        "D": emit_key(KcLeft, 8'h00);
        "H": emit_key(KcHome, 8'h00);
        "F": emit_key(KcEnd, 8'h00);
        "Z": emit_key(KcBackTab, 8'h00);
        "<": begin
          for (int i = 0; i < 3; i++) num_field[i] = '0;
          fld_sel = 0; guard_cnt = 0;
          phase = PhMouse;
        end
        "?": begin_drain();
        default: begin
          if (digit_byte(b)) phase = PhCsiDigit;
          else emit_key(KcEsc, ByteEsc);
        end
      endcase
    end else if (seq_first == "O") begin
      case (b)
        "H": emit_key(KcHome, 8'h00);
        "F": emit_key(KcEnd, 8'h00);
        "P": emit_key(KcF1, 8'h00);
        "Q": emit_key(KcF2, 8'h00);
        "R": emit_key(KcF3, 8'h00);
        "S": emit_key(KcF4, 8'h00);
        default: emit_key(KcEsc, ByteEsc);
      endcase
    end else begin
      emit_key(KcEsc, ByteEsc);
    end
  endtask

  // Second byte of ESC [ digit: tilde keys, paste start, F13 form, CSI-u or modifier.
  task automatic finish_csi_digit(input logic [7:0] b);
    if (b == "~") begin
      case (seq_second)
        "1", "7": emit_key(KcHome, 8'h00);
        "4", "8": emit_key(KcEnd, 8'h00);
        "3":      emit_key(KcDel, 8'h00);
        "5":      emit_key(KcPgUp, 8'h00);
        "6":      emit_key(KcPgDn, 8'h00);
        default:  emit_key(KcEsc, ByteEsc);
      endcase
    end else if (seq_second == "2" && b == "0") begin
      phase = PhPasteDigit;
    end else if (seq_second == "1" && b == "3") begin
      phase = PhF13Term;
    end else if (digit_byte(b)) begin
      num_field[0] = 16'((seq_second - 8'h30) * 10 + (b - 8'h30));
      num_field[1] = '0; num_field[2] = '0;
      fld_sel = 0; guard_cnt = 0;
      phase = PhCsiu;
    end else if (b == ";") begin
      phase = PhNavMod;
    end else begin
      emit_key(KcEsc, ByteEsc);
    end
  endtask

  // Advance the predictor by one accepted input word.
  task automatic predict_key(input tksd_in_t w);
    logic [7:0] b;
    tksd_out_t ev;
    b = w.data_byte;
    if (w.command) begin
      // A timeout while idle is silent; anywhere else it flushes an ESC.
      if (phase == PhIdle) return;
      emit_key(KcEsc, ByteEsc);
      return;
    end
    case (phase)
      PhEsc: begin
        if (b == "b") emit_key(KcALeft, 8'h00);
        else if (b == "f") emit_key(KcARight, 8'h00);
        else begin
          seq_first = b;
          phase = PhIntro;
        end
      end
      PhIntro: begin
        seq_second = b;
        finish_intro(b);
      end
      PhCsiDigit: finish_csi_digit(b);
      PhPasteDigit: begin
        mod_byte = b;
        phase = PhPasteTerm;
      end
      PhPasteTerm: begin
        if (b == "~" && mod_byte == "0") emit_key(KcPaste, 8'h00);
        else emit_key(KcEsc, ByteEsc);
      end
      PhF13Term: begin
        if (b == "~") emit_key(KcF3, 8'h00);
        else emit_key(KcEsc, ByteEsc);
      end
      PhCsiu: begin
        guard_cnt++;
        if (digit_byte(b)) begin
          add_digit(b);
          if (guard_cnt >= KeyGuard) emit_key(KcEsc, ByteEsc);
        end else if (b == ";") begin
          if (fld_sel >= 1) begin_drain();
          else begin
            fld_sel++;
            if (guard_cnt >= KeyGuard) emit_key(KcEsc, ByteEsc);
          end
        end else if (b == "u") begin
          if (fld_sel == 1) finish_csiu();
          else emit_key(KcEsc, ByteEsc);
        end else begin
          begin_drain();
        end
      end
      PhMouse: begin
        guard_cnt++;
        if (digit_byte(b)) begin
          add_digit(b);
          if (guard_cnt >= MouseGuard) begin_drain();
        end else if (b == ";") begin
          if (fld_sel >= 2) begin_drain();
          else begin
            fld_sel++;
            if (guard_cnt >= MouseGuard) begin_drain();
          end
        end else if (b == "M" || b == "m") begin
          if (fld_sel != 2) begin_drain();
          else begin
            ev = '0;
            ev.key_code = KcMouse;
            ev.mouse_button = num_field[0];
            ev.mouse_column = num_field[1];
            ev.mouse_row = num_field[2];
            ev.mouse_pressed = (b == "M");
            key_events.push_back(ev);
            phase = PhIdle;
          end
        end else begin
          begin_drain();
        end
      end
      PhNavMod: begin
        mod_byte = b;
        phase = PhNavTerm;
      end
      PhNavTerm: finish_nav(b);
      PhDrain: begin
        drain_cnt++;
        if (final_byte(b) || drain_cnt >= DrainLimit) emit_key(KcEsc, ByteEsc);
      end
      default: begin
        if (b == ByteEsc) phase = PhEsc;
        else emit_key(KcPlain, b);
      end
    endcase
  endtask

  // Random wait: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  logic burst_mode = 1'b0;  // no idling on either side while set

  // Drive one word and wait until the decoder accepts it. Valid stays high after
  // the handshake so that back-to-back words need no extra edge; a gap or a drain
  // wait drops it.
  task automatic send_word(input logic cmd, input logic [7:0] b);
    int gap;
    tksd_in_t w;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    w.command = cmd;
    w.data_byte = b;
    in_ch.data <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_key(w);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic send_timeout();
    send_word(1'b1, 8'h00);
  endtask

  // Wait until every queued key event has come out, then a few more cycles.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (key_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mapping(input logic v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    super_map = v;
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stalls on ready and an in-order field compare.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ch.ready <= burst_mode ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk_i) begin
    tksd_out_t exp_ev, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      events_seen++;
      if (key_events.size() == 0) begin
        $display("%0t: unexpected key event, got %p", $time, got);
        errors++;
      end else begin
        exp_ev = key_events.pop_front();
        if (got.key_code !== exp_ev.key_code)
          $display("%0t: key_code expected %0d actual %0d", $time, exp_ev.key_code,
                   got.key_code);
        if (got.key_value !== exp_ev.key_value)
          $display("%0t: key_value expected %h actual %h", $time, exp_ev.key_value,
                   got.key_value);
        if (got.mouse_button !== exp_ev.mouse_button)
          $display("%0t: mouse_button expected %0d actual %0d", $time,
                   exp_ev.mouse_button, got.mouse_button);
        if (got.mouse_column !== exp_ev.mouse_column)
          $display("%0t: mouse_column expected %0d actual %0d", $time,
                   exp_ev.mouse_column, got.mouse_column);
        if (got.mouse_row !== exp_ev.mouse_row)
          $display("%0t: mouse_row expected %0d actual %0d", $time, exp_ev.mouse_row,
                   got.mouse_row);
        if (got.mouse_pressed !== exp_ev.mouse_pressed)
          $display("%0t: mouse_pressed expected %0d actual %0d", $time,
                   exp_ev.mouse_pressed, got.mouse_pressed);
        if (got !== exp_ev) errors++;
      end
    end
  end

  // Watchdog: too many cycles with no handshake on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed: plain bytes, ESC shortcuts, SS3 and basic CSI keys, timeouts.
  task automatic test_basic_keys();
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b1, 8'hFF);
    send_text("\033b\033f\033OH\033OS\033Ox\033[A\033[Z\033[3~\033[9~\033[x");
    send_word(1'b0, ByteEsc);
    send_timeout();
    send_text("\033[200~\033[13~\033[1;2A\033[5;6~\033[1;3D");
  endtask

  // Directed: CSI-u with and without the Super mapping, both mapping settings.
  task automatic test_csiu_mapping();
    send_text("\033[99;5u\033[115;6u\033[115;9u\033[98;9u");
    write_mapping(1'b1);
    send_text("\033[115;9u\033[98;9u\033[97;5u");
    write_mapping(1'b0);
    send_text("\033[11;2;3u\033[12u\033[1111111111111111");
  endtask

  // Directed: mouse reports, saturation, short reports and drains.
  task automatic test_mouse_and_drain();
    send_text("\033[<0;1;1M\033[<99999;65535;70000m\033[<1;2M");
    send_text("\033[?1;2;3;4;5;6;7;8;9;0;1;2;3;4;5;6;7");
    send_text("\033[?25h\033[1;5\001");
    send_word(1'b0, 8'h7F);
    send_text("\033[<1;2;3;4");
    send_timeout();
  endtask

  // Build one random sequence, mostly well formed.
  task automatic send_random_sequence();
    int kind;
    string s;
    s = "ABCDHFPQRSX";
    kind = $urandom_range(0, 11);
    case (kind)
      0: send_word(1'b0, 8'($urandom_range(0, 255)));
      1: send_word(1'b1, 8'($urandom_range(0, 255)));
      2: send_text($sformatf("\033O%c", 8'($urandom_range(8'h40, 8'h5A))));
      3: send_text($sformatf("\033[%c", 8'($urandom_range(8'h30, 8'h5A))));
      4: begin
        send_text($sformatf("\033[%c", 8'($urandom_range(8'h31, 8'h38))));
        if ($urandom_range(0, 3) != 0) send_word(1'b0, "~");
        else send_word(1'b0, 8'($urandom_range(0, 255)));
      end
      5: send_text($sformatf("\033[%0d;%0d%c", $urandom_range(1, 6), $urandom_range(1, 6),
                   ($urandom_range(0, 1) != 0) ? 8'h7E : s[$urandom_range(0, 10)]));
      6, 7: send_text($sformatf("\033[%0d;%0du", $urandom_range(10, 130),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 5 + 4 *
                      $urandom_range(0, 1)));
      8, 9: begin
        send_text($sformatf("\033[<%0d;%0d;%0d", $urandom_range(0, 3) == 0 ?
                  $urandom_range(0, 999999) : $urandom_range(0, 64),
                  $urandom_range(1, 300), $urandom_range(1, 100)));
        send_word(1'b0, 8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255) :
                  ($urandom_range(0, 1) ? "M" : "m")));
      end
      10: begin
        send_text("\033[?");
        repeat ($urandom_range(0, 20)) send_word(1'b0, 8'($urandom_range(0, 255)));
      end
      default: begin
        send_word(1'b0, ByteEsc);
        repeat ($urandom_range(0, 4)) send_word($urandom_range(0, 9) == 0,
                                                8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Random: sequences under random idling, drained mapping writes in one window, a burst phase.
  task automatic test_random_stream();
    while (words_sent < 500) begin
      send_random_sequence();
      if (words_sent > 300 && words_sent < 330) begin
        wait_drained();
        write_mapping(1'($urandom_range(0, 1)));
      end
    end
    wait_drained();
    burst_mode = 1'b1;
    repeat (60) send_random_sequence();
    burst_mode = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    clear_predictor();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_keys();
    test_csiu_mapping();
    test_mouse_and_drain();
    test_random_stream();
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d input words and %0d key events: plain bytes, ESC, SS3,",
             words_sent, events_seen);
    $display("CSI keys, CSI-u with both mapping settings, mouse reports, drains, timeouts.");
    if (errors == 0 && key_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tksd_pkg.sv
rtl/core/tksd_if.sv
rtl/core/tksd_parser.sv
rtl/core/terminal_key_sequence_decoder_core.sv
verif/terminal_key_sequence_decoder_core_tb.sv
